// ===== hw/rtl/cesd_pkg.sv =====
package cesd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam int unsigned QDepth = 3;

  typedef enum logic [5:0] {
    MODE_PLAIN = 6'b000001,
    MODE_ESC   = 6'b000010,
    MODE_HEX   = 6'b000100,
    MODE_OCT   = 6'b001000,
    MODE_ZERO  = 6'b010000,
    MODE_DROP  = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] accum;
    logic [1:0] digits;
  } state_t;

  typedef struct packed {
    state_t     nxt;
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
  } step_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       room;
  } q_status_t;

  // {hit, value}
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // {hit, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_7);
  endfunction

endpackage

// ===== hw/rtl/cesd_in_if.sv =====
interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/cesd_out_if.sv =====
interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

// ===== hw/rtl/cesd_decode.sv =====
module cesd_decode (
  input  cesd_pkg::state_t cur_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output cesd_pkg::step_t  step_o
);

  cesd_pkg::step_t s;
  cesd_pkg::res_t  pr;
  cesd_pkg::state_t pst;
  logic [8:0]      sim;
  logic [4:0]      hx;
  logic [7:0]      acc;

  cesd_pkg::res_t  err_r;
  cesd_pkg::state_t err_s;

  always_comb begin
    err_r.kind = cesd_pkg::KIND_ERROR;
    err_r.data = 8'd0;
    err_r.last = last_i;
    err_s.mode = last_i ? cesd_pkg::MODE_PLAIN : cesd_pkg::MODE_DROP;
    err_s.accum = 8'd0;
    err_s.digits = 2'd0;

    // plain text handling of the current byte
    if (byte_i == cesd_pkg::CH_BSLASH) begin
      pr.kind = cesd_pkg::KIND_ERROR;
      pr.data = 8'd0;
      pr.last = 1'b1;
      pst.mode = last_i ? cesd_pkg::MODE_PLAIN : cesd_pkg::MODE_ESC;
    end else begin
      pr.kind = cesd_pkg::KIND_BYTE;
      pr.data = byte_i;
      pr.last = last_i;
      pst.mode = cesd_pkg::MODE_PLAIN;
    end
    pst.accum = 8'd0;
    pst.digits = 2'd0;

    sim = cesd_pkg::simple_escape(byte_i);
    hx  = cesd_pkg::hex_value(byte_i);
    acc = 8'd0;

    s.nxt = cur_i;
    s.n_res = 2'd0;
    s.r0 = err_r;
    s.r1 = pr;

    case (cur_i.mode)
      cesd_pkg::MODE_ESC: begin
        if (sim[8]) begin
          s.n_res = 2'd1;
          s.r0 = '{kind: cesd_pkg::KIND_BYTE, data: sim[7:0], last: last_i};
          s.nxt = '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
        end else if (byte_i == cesd_pkg::CH_X) begin
          if (last_i) begin
            s.n_res = 2'd1;
            s.nxt = err_s;
          end else begin
            s.nxt = '{mode: cesd_pkg::MODE_HEX, accum: 8'd0, digits: 2'd0};
          end
        end else if (byte_i == cesd_pkg::CH_0) begin
          if (last_i) begin
            s.n_res = 2'd1;
            s.r0 = '{kind: cesd_pkg::KIND_BYTE, data: 8'd0, last: 1'b1};
            s.nxt = '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
          end else begin
            s.nxt = '{mode: cesd_pkg::MODE_ZERO, accum: 8'd0, digits: 2'd0};
          end
        end else if (byte_i >= cesd_pkg::CH_1 && byte_i <= cesd_pkg::CH_7) begin
          if (last_i) begin
            s.n_res = 2'd1;
            s.nxt = err_s;
          end else begin
            s.nxt = '{mode: cesd_pkg::MODE_OCT, accum: {5'd0, byte_i[2:0]}, digits: 2'd1};
          end
        end else begin
          s.n_res = 2'd1;
          s.nxt = err_s;
        end
      end
      cesd_pkg::MODE_HEX: begin
        acc = {cur_i.accum[3:0], hx[3:0]};
        if (!hx[4]) begin
          s.n_res = 2'd1;
          s.nxt = err_s;
        end else if (cur_i.digits != 2'd0) begin
          s.n_res = 2'd1;
          s.r0 = '{kind: cesd_pkg::KIND_BYTE, data: acc, last: last_i};
          s.nxt = '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
        end else if (last_i) begin
          s.n_res = 2'd1;
          s.nxt = err_s;
        end else begin
          s.nxt = '{mode: cesd_pkg::MODE_HEX, accum: acc, digits: 2'd1};
        end
      end
      cesd_pkg::MODE_OCT: begin
        acc = {cur_i.accum[4:0], byte_i[2:0]};
        if (!cesd_pkg::is_octal(byte_i)) begin
          s.n_res = 2'd1;
          s.nxt = err_s;
        end else if (cur_i.digits >= 2'd2) begin
          s.n_res = 2'd1;
          s.r0 = '{kind: cesd_pkg::KIND_BYTE, data: acc, last: last_i};
          s.nxt = '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
        end else if (last_i) begin
          s.n_res = 2'd1;
          s.nxt = err_s;
        end else begin
          s.nxt = '{mode: cesd_pkg::MODE_OCT, accum: acc, digits: cur_i.digits + 2'd1};
        end
      end
      cesd_pkg::MODE_ZERO: begin
        if (cesd_pkg::is_octal(byte_i)) begin
          if (last_i) begin
            s.n_res = 2'd1;
            s.nxt = err_s;
          end else begin
            s.nxt = '{mode: cesd_pkg::MODE_OCT, accum: {5'd0, byte_i[2:0]}, digits: 2'd2};
          end
        end else begin
          // NUL, then the byte again as plain text
          s.r0 = '{kind: cesd_pkg::KIND_BYTE, data: 8'd0, last: 1'b0};
          s.r1 = pr;
          s.n_res = (byte_i == cesd_pkg::CH_BSLASH && !last_i) ? 2'd1 : 2'd2;
          s.nxt = pst;
        end
      end
      cesd_pkg::MODE_DROP: begin
        if (last_i) begin
          s.n_res = 2'd1;
          s.r0 = '{kind: cesd_pkg::KIND_END, data: 8'd0, last: 1'b1};
          s.nxt = '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
        end
      end
      default: begin
        s.r0 = pr;
        s.n_res = (byte_i == cesd_pkg::CH_BSLASH && !last_i) ? 2'd0 : 2'd1;
        s.nxt = pst;
      end
    endcase
  end

  assign step_o = s;

endmodule

// ===== hw/rtl/cesd_outq.sv =====
module cesd_outq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [1:0]              n_push_i,
  input  cesd_pkg::res_t          r0_i,
  input  cesd_pkg::res_t          r1_i,
  output cesd_pkg::q_status_t     status_o,
  cesd_out_if.source              out_o
);

  cesd_pkg::res_t ent_q [cesd_pkg::QDepth];
  cesd_pkg::res_t ent_d [cesd_pkg::QDepth];
  cesd_pkg::res_t sh    [cesd_pkg::QDepth];
  logic [1:0]     cnt_q, cnt_d, base;
  logic [1:0]     n_eff;
  logic           pop;

  assign pop   = out_o.valid && out_o.ready;
  assign base  = cnt_q - {1'b0, pop};
  assign n_eff = push_i ? n_push_i : 2'd0;

  always_comb begin
    for (int i = 0; i < cesd_pkg::QDepth; i++) begin
      if (pop && i < cesd_pkg::QDepth - 1) begin
        sh[i] = ent_q[i + 1];
      end else begin
        sh[i] = ent_q[i];
      end
    end
    for (int i = 0; i < cesd_pkg::QDepth; i++) begin
      ent_d[i] = sh[i];
      if (n_eff != 2'd0 && base == 2'(i)) begin
        ent_d[i] = r0_i;
      end
      if (n_eff == 2'd2 && base + 2'd1 == 2'(i)) begin
        ent_d[i] = r1_i;
      end
    end
    cnt_d = base + n_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cesd_pkg::QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign out_o.valid    = cnt_q != 2'd0;
  assign out_o.out_kind = ent_q[0].kind;
  assign out_o.out_byte = ent_q[0].data;
  assign out_o.out_last = ent_q[0].last;

  // two free slots needed, counting this cycle's pop
  assign status_o.cnt  = cnt_q;
  assign status_o.room = (cnt_q <= 2'd1) || (cnt_q == 2'd2 && out_o.ready);

endmodule

// ===== hw/rtl/c_escape_sequence_decoder_top.sv =====
// Results are registered in the 3-entry result queue before the output.
// Throughput: one request per cycle while that queue has room for two results;
//   a zero escape followed by a plain byte makes two results, and the queue
//   drains one per cycle while out_o.ready is high. Reset (rst_ni low,
//   asynchronous): plain text mode, escape state and result queue cleared.
module c_escape_sequence_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cesd_in_if.sink   in_i,
  cesd_out_if.source out_o
);

  cesd_pkg::state_t    st_q;
  cesd_pkg::step_t     step;
  cesd_pkg::q_status_t qs;
  logic                in_acc;

  assign in_i.ready = qs.room;
  assign in_acc     = in_i.valid && in_i.ready;

  cesd_decode u_decode (
    .cur_i  (st_q),
    .byte_i (in_i.in_byte),
    .last_i (in_i.in_last),
    .step_o (step)
  );

  cesd_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_acc),
    .n_push_i (step.n_res),
    .r0_i     (step.r0),
    .r1_i     (step.r1),
    .status_o (qs),
    .out_o    (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: cesd_pkg::MODE_PLAIN, accum: 8'd0, digits: 2'd0};
    end else if (in_acc) begin
      st_q <= step.nxt;
    end
  end

  a_res_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && step.n_res != 2'd0 |=> out_o.valid)
    else $error("result of accepted request not visible");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> qs.cnt >= 2'd2)
    else $error("input stalled with queue room");

  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.mode == cesd_pkg::MODE_DROP |-> st_q.digits == 2'd0 && st_q.accum == 8'd0)
    else $error("escape state not cleared in drop mode");

endmodule
